/* sv/mmrs_pkg.sv */
// shared types and constants for the streaming matrix multiply
`default_nettype none
package mmrs_pkg;

  // default largest matrix dimension
  localparam int unsigned MAX_DIM_DEF = 8;

  // field widths
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned PROD_W    = 36;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  // item kinds carried in s_tuser
  typedef enum logic {
    CMD_LOAD_B = 1'b0,
    CMD_A_ELEM = 1'b1
  } cmd_t;

  // configuration register indexes
  typedef enum logic {
    REG_INNER_LEN = 1'b0,
    REG_OUT_COLS  = 1'b1
  } reg_idx_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_b;
    logic take_a;
    logic issue;
    logic clear;
  } dp_cmd_t;

endpackage
`default_nettype wire

/* sv/mmrs_dp.sv */
// datapath: b store, shared multiplier and per-column accumulators
`default_nettype none
module mmrs_dp #(
  parameter int unsigned MAX_DIM = mmrs_pkg::MAX_DIM_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire mmrs_pkg::dp_cmd_t                      dp_cmd,
  input  wire logic [mmrs_pkg::IDX_W-1:0]             b_row,
  input  wire logic [mmrs_pkg::IDX_W-1:0]             b_col,
  input  wire logic signed [mmrs_pkg::VALUE_W-1:0]    value,
  input  wire logic [$clog2(MAX_DIM)-1:0]             k_idx,
  input  wire logic [$clog2(MAX_DIM)-1:0]             issue_col,
  input  wire logic [$clog2(MAX_DIM)-1:0]             emit_col,
  output logic                                        dp_busy,
  output logic signed [mmrs_pkg::PROD_W-1:0]          product
);
  import mmrs_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM);
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic signed [VALUE_W-1:0]   b_mem [DEPTH];
  logic signed [VALUE_W-1:0]   b_q;
  logic signed [VALUE_W-1:0]   a_reg;
  logic signed [2*VALUE_W-1:0] prod;
  logic                        v1;
  logic                        v2;
  logic [DIM_W-1:0]            col1;
  logic [DIM_W-1:0]            col2;
  logic signed [PROD_W-1:0]    acc [MAX_DIM];

  logic                        wr_ok;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;
  logic [DIM_W-1:0]            acc_idx;
  logic signed [PROD_W-1:0]    acc_rd;
  logic signed [PROD_W-1:0]    acc_sum;

  // b store addressing, writes outside the matrix are dropped
  assign wr_ok   = (32'(b_row) < MAX_DIM) && (32'(b_col) < MAX_DIM);
  assign wr_addr = AW'(32'(b_row) * MAX_DIM + 32'(b_col));
  assign rd_addr = AW'(32'(k_idx) * MAX_DIM + 32'(issue_col));

  // b store, registered read
  always_ff @(posedge clk) begin
    if (dp_cmd.load_b && wr_ok) begin
      b_mem[wr_addr] <= value;
    end
    b_q <= b_mem[rd_addr];
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= dp_cmd.issue;
      v2 <= v1;
    end
  end

  // operand hold, column tags and product register
  always_ff @(posedge clk) begin
    if (dp_cmd.take_a) begin
      a_reg <= value;
    end
    col1 <= issue_col;
    col2 <= col1;
    prod <= a_reg * b_q;
  end

  // one accumulator port: mac write-back or result read
  assign acc_idx = v2 ? col2 : emit_col;
  assign acc_rd  = acc[acc_idx];
  assign acc_sum = acc_rd + PROD_W'(prod);

  // accumulators
  always_ff @(posedge clk) begin
    if (rst || dp_cmd.clear) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        acc[i] <= '0;
      end
    end else if (v2) begin
      acc[col2] <= acc_sum;
    end
  end

  assign dp_busy = v1 | v2;
  assign product = acc_rd;

endmodule
`default_nettype wire

/* sv/mmrs_ctrl.sv */
// controller: item sequencing, column issue and result emission
`default_nettype none
module mmrs_ctrl #(
  parameter int unsigned MAX_DIM = mmrs_pkg::MAX_DIM_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic                          cmd,
  input  wire logic [mmrs_pkg::CFG_W-1:0]    inner_len,
  input  wire logic [mmrs_pkg::CFG_W-1:0]    out_cols,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic                               m_tlast,
  output mmrs_pkg::dp_cmd_t                  dp_cmd,
  output logic [$clog2(MAX_DIM)-1:0]         k_idx,
  output logic [$clog2(MAX_DIM)-1:0]         issue_col,
  output logic [$clog2(MAX_DIM)-1:0]         emit_col,
  input  wire logic                          dp_busy
);
  import mmrs_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM);
  localparam int unsigned CNT_W = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t           state;
  logic [DIM_W-1:0] count;
  logic             row_done;

  logic [CNT_W-1:0] n_inner;
  logic [CNT_W-1:0] n_cols;
  logic             accept_a;
  logic             row_end;
  logic             last_col;

  // out-of-range dimension maps to 1 or MAX_DIM
  function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  assign n_inner  = eff_dim(inner_len);
  assign n_cols   = eff_dim(out_cols);
  assign accept_a = s_tvalid && s_tready && (cmd == CMD_A_ELEM);
  assign row_end  = ((CNT_W + 1)'(count) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(n_inner);
  assign last_col = (CNT_W'(emit_col) + CNT_W'(1)) == n_cols;

  // handshake and datapath commands
  assign s_tready      = (state == ST_IDLE);
  assign m_tvalid      = (state == ST_EMIT);
  assign m_tlast       = last_col;
  assign dp_cmd.load_b = s_tvalid && s_tready && (cmd == CMD_LOAD_B);
  assign dp_cmd.take_a = accept_a;
  assign dp_cmd.issue  = (state == ST_MAC);
  assign dp_cmd.clear  = m_tvalid && m_tready && last_col;

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      row_done  <= 1'b0;
      k_idx     <= '0;
      issue_col <= '0;
      emit_col  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept_a) begin
            k_idx     <= count;
            row_done  <= row_end;
            count     <= row_end ? '0 : count + DIM_W'(1);
            issue_col <= '0;
            state     <= ST_MAC;
          end
        end
        ST_MAC: begin
          issue_col <= issue_col + DIM_W'(1);
          if (issue_col == DIM_W'(MAX_DIM - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!dp_busy) begin
            if (row_done) begin
              emit_col <= '0;
              state    <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (m_tready) begin
            if (last_col) begin
              state <= ST_IDLE;
            end else begin
              emit_col <= emit_col + DIM_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // input and output sides never open together
  a_side_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output sides open at once");

  // datapath pipeline only runs during a column pass
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    dp_busy |-> (state == ST_MAC || state == ST_DRAIN))
    else $error("datapath busy outside column pass");

  // closing a row returns to idle with the inner counter cleared
  a_row_close: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.clear |=> (s_tready && count == '0))
    else $error("row close left stale state");

  // emitted column stays within the result row
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CNT_W'(emit_col) < n_cols))
    else $error("emitted column beyond row length");

endmodule
`default_nettype wire

/* sv/matrix_multiply_row_stream_top.sv */
// top level: stream ports, configuration registers, controller and datapath
//
// Computes C = A x B in signed fixed point. B is loaded first, one Q4.12
// element per transfer with s_tuser = 0, at (b_row, b_col). Rows of A
// follow with s_tuser = 1, inner_len elements per row in inner-index order.
// An A element is not accepted until the previous one has passed through
// every column: a single shared 16x16 multiplier walks all MAX_DIM
// columns one per cycle, through a registered B store read, a product
// register and the accumulator write-back. After the last element of a row
// the block sends out_cols Q12.24 results in column order, one per cycle
// while m_tready is high, with m_tlast on the final one, and then clears
// the accumulators. No input is taken while results are being sent. B
// entries that were never written read back as undefined values.
`default_nettype none
module matrix_multiply_row_stream_top #(
  parameter int unsigned MAX_DIM = mmrs_pkg::MAX_DIM_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // s_tdata: b_row[2:0], b_col[5:3], value[21:6], zero[23:22]
  input  wire logic [mmrs_pkg::S_TDATA_W-1:0]     s_tdata,
  // s_tuser: cmd[0]
  input  wire logic [0:0]                         s_tuser,
  // result stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // m_tdata: product[35:0], col_index[38:36], zero[39]
  output logic [mmrs_pkg::M_TDATA_W-1:0]          m_tdata,
  output logic                                    m_tlast,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mmrs_pkg::APB_AW-1:0]        paddr,
  input  wire logic [mmrs_pkg::APB_DW-1:0]        pwdata,
  output logic [mmrs_pkg::APB_DW-1:0]             prdata,
  output logic                                    pready
);
  import mmrs_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM);

  logic [CFG_W-1:0]          inner_len;
  logic [CFG_W-1:0]          out_cols;
  logic                      cfg_wr;
  reg_idx_t                  reg_idx;
  logic [CFG_W-1:0]          rd_val;

  logic [IDX_W-1:0]          b_row;
  logic [IDX_W-1:0]          b_col;
  logic signed [VALUE_W-1:0] value;
  logic signed [PROD_W-1:0]  product;
  logic [IDX_W-1:0]          col_index;

  dp_cmd_t                   dp_cmd;
  logic [DIM_W-1:0]          k_idx;
  logic [DIM_W-1:0]          issue_col;
  logic [DIM_W-1:0]          emit_col;
  logic                      dp_busy;

  // input field unpacking
  assign b_row = s_tdata[2:0];
  assign b_col = s_tdata[5:3];
  assign value = s_tdata[21:6];

  // configuration write and read decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      REG_INNER_LEN: rd_val = inner_len;
      REG_OUT_COLS:  rd_val = out_cols;
      default:       rd_val = '0;
    endcase
  end

  assign prdata = APB_DW'(rd_val);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_len <= CFG_W'(8);
      out_cols  <= CFG_W'(8);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_INNER_LEN: inner_len <= pwdata[CFG_W-1:0];
        REG_OUT_COLS:  out_cols  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  mmrs_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cmd       (s_tuser[0]),
    .inner_len (inner_len),
    .out_cols  (out_cols),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tlast   (m_tlast),
    .dp_cmd    (dp_cmd),
    .k_idx     (k_idx),
    .issue_col (issue_col),
    .emit_col  (emit_col),
    .dp_busy   (dp_busy)
  );

  mmrs_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .b_row     (b_row),
    .b_col     (b_col),
    .value     (value),
    .k_idx     (k_idx),
    .issue_col (issue_col),
    .emit_col  (emit_col),
    .dp_busy   (dp_busy),
    .product   (product)
  );

  // result packing
  assign col_index = IDX_W'(emit_col);
  assign m_tdata   = {1'b0, col_index, product};

endmodule
`default_nettype wire
